[rtl/core/rsrl_pkg.sv]
// Shared widths, codes and row layout for the range set rank lookup block.
package rsrl_pkg;

  // Table size and field widths
  localparam int unsigned MAX_RANGES = 256;
  localparam int unsigned ADDR_W     = $clog2(MAX_RANGES);
  localparam int unsigned CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int unsigned IDX_W      = 32;
  localparam int unsigned RANK_W     = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned ROW_W      = 2 * IDX_W + RANK_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK            = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_ASCENDING = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL          = 2'd2;

  // One stored range: first index, inclusive last index, entries before it
  typedef struct packed {
    logic [IDX_W-1:0]  start;
    logic [IDX_W-1:0]  last;
    logic [RANK_W-1:0] rank_base;
  } range_row_t;

endpackage

[rtl/core/rsrl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rsrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/range_set_rank_lookup_top.sv]
// Top level of the range set rank lookup block: sequencer, range table and result register.
//
// Input channel (in_valid_i, in_stall_o, op_i, value_i) carries one operation per
// transfer: clear the set, append the next strictly ascending index, or query an index.
// Output channel (out_valid_o, out_stall_i, found_o, position_o, status_o) returns
// exactly one result per input transfer, in order.
// Clear, append and unused op codes pass their result through the result registers and
// then the output register. A query runs a binary search over the range table through
// the single read port of the table RAM, each probe setting the read address in S_QRD
// and comparing the registered row in S_QCMP.
// One item is worked on at a time; in_stall_o is high from the input transfer until
// the result has been loaded into the output register. The next transfer can come in the
// cycle after that load, so a new item is never accepted while the last one is in work.
// The output register lets the next item start while a result still waits to be taken.
// When the receiver stalls, the result holds steady and a finished next result waits
// in the sequencer until the output register frees up.
// Reset empties the set (no ranges, no entries) and drops any pending result. The
// table RAM needs no clearing: only rows below the range count are ever read.
module range_set_rank_lookup_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rsrl_pkg::OP_W-1:0]     op_i,
  input  logic [rsrl_pkg::IDX_W-1:0]    value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [rsrl_pkg::RANK_W-1:0]   position_o,
  output logic [rsrl_pkg::STAT_W-1:0]   status_o
);

  import rsrl_pkg::*;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_QRD  = 2'd1;
  localparam logic [1:0] S_QCMP = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [RANK_W-1:0] total_q, total_d;
  range_row_t        top_q, top_d;
  logic [IDX_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]  lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  range_row_t        cand_q, cand_d;
  logic              hit_q, hit_d;

  logic              res_found_q, res_found_d;
  logic [RANK_W-1:0] res_pos_q, res_pos_d;
  logic [STAT_W-1:0] res_stat_q, res_stat_d;

  logic              out_valid_q;
  logic              out_found_q;
  logic [RANK_W-1:0] out_pos_q;
  logic [STAT_W-1:0] out_stat_q;

  logic              in_xfer;
  logic              out_free;
  logic              out_load;
  logic [CNT_W-1:0]  mid_calc;
  logic [CNT_W-1:0]  count_m1;
  logic [IDX_W:0]    top_next;
  logic              q_found;
  logic [RANK_W-1:0] q_rank;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  range_row_t        ram_wdata;
  logic [ROW_W-1:0]  ram_rdata;
  range_row_t        rd_row;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_DONE) && out_free;

  assign mid_calc = lo_q + ((hi_q - lo_q) >> 1);
  assign count_m1 = count_q - CNT_W'(1);
  assign top_next = {1'b0, top_q.last} + (IDX_W + 1)'(1);
  assign rd_row   = range_row_t'(ram_rdata);

  // Final check against the last range whose start is not above the key
  assign q_found = hit_q && (key_q <= cand_q.last);
  assign q_rank  = cand_q.rank_base + RANK_W'(key_q - cand_q.start);

  // Sequencer and table bookkeeping
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    top_d       = top_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    cand_d      = cand_q;
    hit_d       = hit_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    res_stat_d  = res_stat_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[ADDR_W-1:0];
    ram_wdata   = top_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_found_d = 1'b0;
          res_pos_d   = '0;
          res_stat_d  = ST_OK;
          state_d     = S_DONE;
          unique case (op_i)
            OP_CLEAR: begin
              count_d = '0;
              total_d = '0;
            end
            OP_APPEND: begin
              priority if (count_q != '0 && value_i <= top_q.last) begin
                res_stat_d = ST_NOT_ASCENDING;
              end else if (count_q != '0 && {1'b0, value_i} == top_next) begin
                // Extend the newest range
                top_d.last = value_i;
                total_d    = total_q + RANK_W'(1);
                ram_we     = 1'b1;
                ram_waddr  = count_m1[ADDR_W-1:0];
                ram_wdata  = top_d;
              end else if (count_q == CNT_W'(MAX_RANGES)) begin
                res_stat_d = ST_FULL;
              end else begin
                // Open a new range
                top_d.start     = value_i;
                top_d.last      = value_i;
                top_d.rank_base = total_q;
                count_d         = count_q + CNT_W'(1);
                total_d         = total_q + RANK_W'(1);
                ram_we          = 1'b1;
                ram_waddr       = count_q[ADDR_W-1:0];
                ram_wdata       = top_d;
              end
            end
            OP_QUERY: begin
              key_d   = value_i;
              lo_d    = '0;
              hi_d    = count_q;
              hit_d   = 1'b0;
              state_d = S_QRD;
            end
            default: begin
            end
          endcase
        end
      end
      S_QRD: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_calc;
          state_d = S_QCMP;
        end else begin
          res_found_d = q_found;
          res_pos_d   = q_found ? q_rank : '0;
          state_d     = S_DONE;
        end
      end
      S_QCMP: begin
        if (rd_row.start <= key_q) begin
          lo_d   = mid_q + CNT_W'(1);
          cand_d = rd_row;
          hit_d  = 1'b1;
        end else begin
          hi_d = mid_q;
        end
        state_d = S_QRD;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      total_q <= '0;
      hit_q   <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      hit_q   <= hit_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    top_q       <= top_d;
    key_q       <= key_d;
    mid_q       <= mid_d;
    cand_q      <= cand_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    res_stat_q  <= res_stat_d;
  end

  // Output register: load a finished result, drop it on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= res_found_q;
      out_pos_q   <= res_pos_q;
      out_stat_q  <= res_stat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign position_o  = out_pos_q;
  assign status_o    = out_stat_q;

  // Range table: start, last and entries before, one row per range
  rsrl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_RANGES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (mid_d[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RANGES))
    else $error("range count above table size");

  a_probe_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QCMP) |-> (lo_q <= mid_q) && (mid_q < hi_q))
    else $error("search probe outside the live window");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (status_o == ST_OK))
    else $error("found result with error status");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (position_o == '0))
    else $error("miss result with nonzero position");

  a_busy_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != S_IDLE))
    else $error("accepted item left no work in the sequencer");
`endif

endmodule
